// ===== rtl/olist_pkg.sv =====
`timescale 1ns / 1ps
package olist_pkg;

    localparam int StatusW = 3;
    localparam int ReqW    = 2;
    localparam int CountW  = 5;

    localparam logic [ReqW-1:0] REQ_APPEND = 2'd0;
    localparam logic [ReqW-1:0] REQ_DELETE = 2'd1;
    localparam logic [ReqW-1:0] REQ_SEARCH = 2'd2;

    localparam logic [StatusW-1:0] ST_APPENDED = 3'd0;
    localparam logic [StatusW-1:0] ST_FULL     = 3'd1;
    localparam logic [StatusW-1:0] ST_DELETED  = 3'd2;
    localparam logic [StatusW-1:0] ST_MISSED   = 3'd3;
    localparam logic [StatusW-1:0] ST_FOUND    = 3'd4;
    localparam logic [StatusW-1:0] ST_NOTFOUND = 3'd5;

    typedef struct packed {
        logic               load;       // latch request, restart walk
        logic               append_wr;  // write new word at tail, count up
        logic               rd_en;      // read entry at walk index, index up
        logic               shift_wr;   // move read entry one place toward head
        logic               dec_count;
        logic               finish;     // load result register
        logic [StatusW-1:0] result;
    } olist_cmd_t;

    typedef struct packed {
        logic [ReqW-1:0] in_type;
        logic [ReqW-1:0] cur_type;
        logic            out_busy;
        logic            full;
        logic            empty;
        logic            more;      // walk index below count
        logic            pend_vld;  // read data valid this cycle
        logic            hit;
        logic            last;      // read data is from the tail entry
    } olist_sts_t;

endpackage

// ===== rtl/olist_datapath.sv =====
`timescale 1ns / 1ps
module olist_datapath
    import olist_pkg::*;
#(
    parameter int DEPTH = 16
)(
    input  logic                clk,
    input  logic                rst_n,
    input  olist_cmd_t          cmd,
    output olist_sts_t          sts,
    input  logic [ReqW-1:0]     in_type,
    input  logic signed [31:0]  in_value,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [StatusW-1:0]  out_status,
    output logic [CountW-1:0]   out_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [31:0]        mem [DEPTH];

    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic               pend_vld_reg, pend_vld_next;
    logic [AW-1:0]      pend_idx_reg;
    logic [31:0]        rd_data_reg;
    logic [31:0]        key_reg;
    logic [ReqW-1:0]    type_reg;
    logic               out_vld_reg, out_vld_next;
    logic [StatusW-1:0] out_status_reg;
    logic [CountW-1:0]  out_count_reg;

    logic [AW-1:0]      wr_addr;
    logic [31:0]        wr_data;
    logic               wr_en;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.append_wr)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.dec_count)
        begin
            count_next = count_reg - CW'(1);
        end

        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.rd_en)
        begin
            idx_next = idx_reg + CW'(1);
        end

        pend_vld_next = cmd.load ? 1'b0 : cmd.rd_en;

        out_vld_next = out_vld_reg;
        if (cmd.finish)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end

        wr_en   = cmd.append_wr | cmd.shift_wr;
        wr_addr = cmd.append_wr ? count_reg[AW-1:0] : (pend_idx_reg - AW'(1));
        wr_data = cmd.append_wr ? in_value : rd_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            idx_reg      <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg  <= mem[idx_reg[AW-1:0]];
            pend_idx_reg <= idx_reg[AW-1:0];
        end
        if (cmd.load)
        begin
            key_reg  <= in_value;
            type_reg <= in_type;
        end
        if (cmd.finish)
        begin
            out_status_reg <= cmd.result;
            out_count_reg  <= CountW'(count_next);
        end
    end

    always_comb
    begin
        sts.in_type  = in_type;
        sts.cur_type = type_reg;
        sts.out_busy = out_vld_reg & ~out_ready;
        sts.full     = (count_reg == CW'(DEPTH));
        sts.empty    = (count_reg == '0);
        sts.more     = (idx_reg < count_reg);
        sts.pend_vld = pend_vld_reg;
        sts.hit      = (rd_data_reg == key_reg);
        sts.last     = (CW'(pend_idx_reg) == (count_reg - CW'(1)));
    end

    assign out_valid  = out_vld_reg;
    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;

endmodule

// ===== rtl/olist_ctrl.sv =====
`timescale 1ns / 1ps
module olist_ctrl
    import olist_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  olist_sts_t  sts,
    output olist_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = ~sts.out_busy;
                if (in_valid && !sts.out_busy)
                begin
                    cmd.load = 1'b1;
                    priority if (sts.in_type == REQ_APPEND)
                    begin
                        cmd.finish = 1'b1;
                        if (sts.full)
                        begin
                            cmd.result = ST_FULL;
                        end
                        else
                        begin
                            cmd.append_wr = 1'b1;
                            cmd.result    = ST_APPENDED;
                        end
                    end
                    else if (sts.empty)
                    begin
                        cmd.finish = 1'b1;
                        cmd.result = (sts.in_type == REQ_DELETE) ? ST_MISSED : ST_NOTFOUND;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                cmd.rd_en = sts.more;
                if (sts.pend_vld)
                begin
                    priority if (sts.hit)
                    begin
                        if (sts.cur_type == REQ_DELETE)
                        begin
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            cmd.finish = 1'b1;
                            cmd.result = ST_FOUND;
                            state_next = S_IDLE;
                        end
                    end
                    else if (sts.last)
                    begin
                        cmd.finish = 1'b1;
                        cmd.result = (sts.cur_type == REQ_DELETE) ? ST_MISSED : ST_NOTFOUND;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SHIFT:
            begin
                cmd.rd_en = sts.more;
                if (sts.pend_vld)
                begin
                    cmd.shift_wr = 1'b1;
                end
                else
                begin
                    cmd.finish    = 1'b1;
                    cmd.dec_count = 1'b1;
                    cmd.result    = ST_DELETED;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/ordered_value_list.sv =====
`timescale 1ns / 1ps
// channel     | dir | tdata                               | tuser
// s_axis      | in  | [31:0] value (signed)               | [1:0] req_type
// m_axis      | out | [2:0] status, [7:3] entry_count     | -
//
// Append, and delete/search on an empty list, finish from idle without a walk.
// Otherwise search and delete walk the list; the walk reads one entry per cycle
// through the single read port of the entry memory.
// Reset clears the entry count and control state; entries need no clearing.
// A new word is taken only in idle, when the result register is empty or draining.
module ordered_value_list
    import olist_pkg::*;
#(
    parameter int DEPTH = 16
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic signed [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]         s_axis_tuser,   // [1:0] req_type
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata    // [2:0] status, [7:3] entry_count
);

    olist_cmd_t          cmd;
    olist_sts_t          sts;
    logic [StatusW-1:0]  status;
    logic [CountW-1:0]   entry_count;

    olist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    olist_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_type    (s_axis_tuser),
        .in_value   (s_axis_tdata),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_status (status),
        .out_count  (entry_count)
    );

    assign m_axis_tdata = {entry_count, status};

endmodule

// ===== tb/sv/tb_ordered_value_list.sv =====
`timescale 1ns / 1ps
module tb_ordered_value_list;
    import olist_pkg::*;

    localparam int DEPTH      = 16;
    localparam int CLK_PERIOD = 20;
    localparam int MAX_CYCLES = 500000;
    localparam int HOLD_LEN   = 400;
    localparam int RAND_ITEMS = 1920;
    localparam int POOL_SIZE  = 8;

    // code 3 is unassigned; the block treats it as a search
    localparam logic [ReqW-1:0] REQ_RESERVED = 2'd3;

    typedef struct packed {
        logic [ReqW-1:0] kind;
        logic [31:0]     key;
    } list_req_t;

    typedef struct packed {
        logic [StatusW-1:0] status;
        logic [CountW-1:0]  count;
    } list_resp_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic signed [31:0] s_axis_tdata = '0;   // [31:0] value
    logic [1:0]         s_axis_tuser = '0;   // [1:0] req_type
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [7:0]         m_axis_tdata;        // [2:0] status, [7:3] entry_count

    ordered_value_list #(.DEPTH(DEPTH)) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    list_req_t   pending_words[$];
    list_resp_t  expected_resps[$];
    logic [31:0] shadow_list[DEPTH];
    int          shadow_count = 0;
    int          words_sent = 0;
    int          n_total = 0;
    int          err_count = 0;
    int          cycle_count = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    list_req_t   next_word;
    list_resp_t  got_resp;
    list_resp_t  want_resp;

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    task automatic report(input string msg);
        err_count++;
        if (err_count <= 40)
            $display("%0t ns  mismatch: %s", $time, msg);
    endtask

    task automatic queue_word(input logic [ReqW-1:0] kind, input logic [31:0] key);
        list_req_t w;
        w.kind = kind;
        w.key  = key;
        pending_words.push_back(w);
    endtask

    // phase 0: sender 8%, receiver 53%; phase 1: swapped; phase 2: no idling
    function automatic int phase_of(input int sent);
        if (sent < n_total / 3)
            return 0;
        else if (sent < (2 * n_total) / 3)
            return 1;
        return 2;
    endfunction

    function automatic list_resp_t apply_request(input logic [ReqW-1:0] kind,
                                                 input logic [31:0] key);
        list_resp_t r;
        int hit_pos;
        hit_pos = -1;
        for (int i = 0; i < shadow_count; i++)
            if (hit_pos < 0 && shadow_list[i] == key)
                hit_pos = i;
        case (kind)
            REQ_APPEND:
                if (shadow_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    shadow_list[shadow_count] = key;
                    shadow_count++;
                    r.status = ST_APPENDED;
                end
            REQ_DELETE:
                if (hit_pos < 0)
                    r.status = ST_MISSED;
                else
                begin
                    for (int i = hit_pos; i + 1 < shadow_count; i++)
                        shadow_list[i] = shadow_list[i + 1];
                    shadow_count--;
                    r.status = ST_DELETED;
                end
            default:
                r.status = (hit_pos >= 0) ? ST_FOUND : ST_NOTFOUND;
        endcase
        r.count = shadow_count[CountW-1:0];
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_resps.push_back(apply_request(s_axis_tuser, s_axis_tdata));
                words_sent <= words_sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_words.size() != 0 &&
                    $urandom_range(99) >= (phase_of(words_sent) == 0 ? 8 :
                                           phase_of(words_sent) == 1 ? 53 : 0))
                begin
                    next_word = pending_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_word.key;
                    s_axis_tuser  <= next_word.kind;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor and receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_resp.status = m_axis_tdata[2:0];
                got_resp.count  = m_axis_tdata[7:3];
                if (expected_resps.size() == 0)
                    report($sformatf("unexpected word status=%0d count=%0d",
                                     got_resp.status, got_resp.count));
                else
                begin
                    want_resp = expected_resps.pop_front();
                    if (got_resp.status !== want_resp.status)
                        report($sformatf("status got %0d exp %0d",
                                         got_resp.status, want_resp.status));
                    if (got_resp.count !== want_resp.count)
                        report($sformatf("entry_count got %0d exp %0d",
                                         got_resp.count, want_resp.count));
                end
            end
            // one long hold-off early in the no-idle phase: list engine backs up
            if (!hold_done && words_sent >= (2 * n_total) / 3 + 10)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= (phase_of(words_sent) == 0 ? 53 :
                                                        phase_of(words_sent) == 1 ? 8 : 0));
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == MAX_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] key_pool[POOL_SIZE];
        int          append_pct;
        int          roll;
        logic [31:0] key;

        // directed: empty list, extremes, duplicates, head/middle delete, full list
        queue_word(REQ_SEARCH, 32'd5);
        queue_word(REQ_DELETE, 32'd5);
        queue_word(REQ_APPEND, 32'h8000_0000);
        queue_word(REQ_APPEND, 32'h7FFF_FFFF);
        queue_word(REQ_APPEND, 32'h0000_0000);
        queue_word(REQ_APPEND, 32'hFFFF_FFFF);
        queue_word(REQ_APPEND, 32'h7FFF_FFFF);
        queue_word(REQ_SEARCH, 32'h0000_0000);
        queue_word(REQ_SEARCH, 32'h1234_5678);
        queue_word(REQ_RESERVED, 32'h7FFF_FFFF);
        queue_word(REQ_RESERVED, 32'h0000_0001);
        queue_word(REQ_DELETE, 32'h8000_0000);
        queue_word(REQ_DELETE, 32'h7FFF_FFFF);
        queue_word(REQ_DELETE, 32'hFFFF_FFFF);
        queue_word(REQ_DELETE, 32'd5);
        queue_word(REQ_SEARCH, 32'h7FFF_FFFF);
        for (int i = 0; i < DEPTH - 2; i++)
            queue_word(REQ_APPEND, $urandom);
        queue_word(REQ_APPEND, 32'hA5A5_5A5A);

        // random: keys mostly from a small pool so deletes and searches hit,
        // append weight drifts per block so the list swings between empty and full
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        append_pct = 50;
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i % 40 == 0)
                append_pct = $urandom_range(85, 15);
            key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                            : $urandom;
            roll = $urandom_range(99);
            if (roll < append_pct)
                queue_word(REQ_APPEND, key);
            else if (roll < append_pct + (100 - append_pct) * 6 / 10)
                queue_word(REQ_DELETE, key);
            else if (roll < 97)
                queue_word(REQ_SEARCH, key);
            else
                queue_word(REQ_RESERVED, key);
        end
        n_total = pending_words.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_resps.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (expected_resps.size() != 0)
            report($sformatf("%0d expected words never arrived", expected_resps.size()));
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/olist_pkg.sv
rtl/olist_datapath.sv
rtl/olist_ctrl.sv
rtl/ordered_value_list.sv
tb/sv/tb_ordered_value_list.sv
